>>> sv/b64d_pkg.sv
// Shared types, constants and helper functions for the base64 decoder.
// No dependencies; every other file of the block depends on this package.
package b64d_pkg;

	localparam int COUNT_W = 24;
	localparam int ACCUM_W = 18;
	localparam int MAX_BYTES = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [7:0] CH_UP_A = 8'd65;
	localparam logic [7:0] CH_UP_Z = 8'd90;
	localparam logic [7:0] CH_LO_A = 8'd97;
	localparam logic [7:0] CH_LO_Z = 8'd122;
	localparam logic [7:0] CH_DIG_0 = 8'd48;
	localparam logic [7:0] CH_DIG_9 = 8'd57;
	localparam logic [7:0] CH_PLUS = 8'd43;
	localparam logic [7:0] CH_SLASH = 8'd47;

	localparam logic [5:0] SEXTET_PLUS = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;
	localparam logic [7:0] LO_A_OFFSET = 8'd71;
	localparam logic [7:0] DIG_OFFSET = 8'd4;

	// Result of the character lookup; bit 6 set means the character is discarded.
	localparam logic [6:0] SEXTET_NONE = 7'h40;

	// Up to three decoded bytes of one input word with their running counts.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [MAX_BYTES-1:0][COUNT_W-1:0] counts;
		logic [1:0] num;
	} bundle_t;

	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			v = c - CH_UP_A;
			return {1'b0, v[5:0]};
		end
		if (c >= CH_LO_A && c <= CH_LO_Z) begin
			v = c - LO_A_OFFSET;
			return {1'b0, v[5:0]};
		end
		if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
			v = c + DIG_OFFSET;
			return {1'b0, v[5:0]};
		end
		if (c == CH_PLUS) return {1'b0, SEXTET_PLUS};
		if (c == CH_SLASH) return {1'b0, SEXTET_SLASH};
		return SEXTET_NONE;
	endfunction

	// Adds a small step to the byte count, holding at the maximum.
	function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] t,
			input logic [1:0] k);
		logic [COUNT_W:0] sum;
		sum = {1'b0, t} + {{(COUNT_W - 1){1'b0}}, k};
		if (sum[COUNT_W]) return COUNT_MAX;
		return sum[COUNT_W-1:0];
	endfunction

endpackage

>>> sv/b64d_ifs.sv
// Valid/ready channel interfaces for the base64 decoder: text characters in,
// decoded bytes out. Depends on b64d_pkg for the count width.
interface b64d_char_if;
	logic valid;
	logic ready;
	logic [7:0] char_code;
	logic end_of_text;
	modport source(output valid, output char_code, output end_of_text, input ready);
	modport sink(input valid, input char_code, input end_of_text, output ready);
endinterface

interface b64d_byte_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic [b64d_pkg::COUNT_W-1:0] decoded_count;
	logic run_last;
	modport source(output valid, output data_byte, output decoded_count, output run_last,
		input ready);
	modport sink(input valid, input data_byte, input decoded_count, input run_last,
		output ready);
endinterface

>>> sv/b64d_unpack.sv
// Input register, alphabet lookup and group state of the base64 decoder.
// Produces at most one bundle of up to three bytes per word. Depends on b64d_pkg, b64d_ifs.
module b64d_unpack (
	input logic clk,
	input logic arst_n,
	b64d_char_if.sink in_ch,
	output b64d_pkg::bundle_t bundle,
	output logic bundle_valid,
	input logic bundle_ready
);
	import b64d_pkg::*;

	logic valid_s1;
	logic [7:0] char_s1;
	logic end_s1;

	logic [ACCUM_W-1:0] accum_q;
	logic [1:0] fill_q;
	logic [COUNT_W-1:0] total_q;

	logic [6:0] lookup;
	logic sv;
	logic [ACCUM_W-1:0] accum_n;
	logic [1:0] fill_n;
	logic [COUNT_W-1:0] total_n;
	logic [ACCUM_W+5:0] word;
	logic adv;

	assign lookup = sextet_of(char_s1);
	assign sv = ~lookup[6];

	always_comb begin
		accum_n = accum_q;
		fill_n = fill_q;
		word = '0;
		bundle.bytes = '0;
		bundle.num = 2'd0;
		if (sv) begin
			if (fill_q == 2'd3) begin
				word = {accum_q, lookup[5:0]};
				bundle.bytes[0] = word[23:16];
				bundle.bytes[1] = word[15:8];
				bundle.bytes[2] = word[7:0];
				bundle.num = 2'd3;
				accum_n = '0;
				fill_n = 2'd0;
			end else begin
				accum_n = {accum_q[ACCUM_W-7:0], lookup[5:0]};
				fill_n = fill_q + 2'd1;
			end
		end
		if (end_s1) begin
			// A partial group flushes with the missing sextets taken as zero.
			if (fill_n == 2'd2) begin
				bundle.bytes[0] = accum_n[11:4];
				bundle.num = 2'd1;
			end else if (fill_n == 2'd3) begin
				word = {accum_n, 6'd0};
				bundle.bytes[0] = word[23:16];
				bundle.bytes[1] = word[15:8];
				bundle.num = 2'd2;
			end
			accum_n = '0;
			fill_n = 2'd0;
		end
		bundle.counts[0] = sat_add(total_q, 2'd1);
		bundle.counts[1] = sat_add(total_q, 2'd2);
		bundle.counts[2] = sat_add(total_q, 2'd3);
		total_n = end_s1 ? '0 : sat_add(total_q, bundle.num);
	end

	assign bundle_valid = valid_s1 && (bundle.num != 2'd0);
	// A word that yields no bytes never waits on the output side.
	assign adv = valid_s1 && ((bundle.num == 2'd0) || bundle_ready);
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			char_s1 <= in_ch.char_code;
			end_s1 <= in_ch.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			fill_q <= 2'd0;
			total_q <= '0;
		end else if (adv) begin
			accum_q <= accum_n;
			fill_q <= fill_n;
			total_q <= total_n;
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && end_s1 |=> fill_q == 2'd0 && total_q == '0 && accum_q == '0)
		else $error("group state not cleared after end of text");

	a_full_group: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && sv && fill_q == 2'd3 |-> bundle.num == 2'd3)
		else $error("completed group did not yield three bytes");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(char_s1) && $stable(fill_q))
		else $error("stalled word or group state changed");

endmodule

>>> sv/b64d_serial.sv
// Result register of the base64 decoder: holds one bundle and hands its bytes
// out one word per cycle while out_ch is ready. Depends on b64d_pkg and b64d_ifs.
module b64d_serial (
	input logic clk,
	input logic arst_n,
	input b64d_pkg::bundle_t bundle,
	input logic bundle_valid,
	output logic bundle_ready,
	b64d_byte_if.source out_ch
);
	import b64d_pkg::*;

	logic busy_q;
	bundle_t bundle_q;
	logic [1:0] idx_q;
	logic last;

	assign last = idx_q == (bundle_q.num - 2'd1);
	assign bundle_ready = !busy_q || (out_ch.ready && last);

	assign out_ch.valid = busy_q;
	assign out_ch.data_byte = bundle_q.bytes[idx_q];
	assign out_ch.decoded_count = bundle_q.counts[idx_q];
	assign out_ch.run_last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (bundle_ready) begin
			busy_q <= bundle_valid;
			idx_q <= 2'd0;
		end else if (out_ch.ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (bundle_ready && bundle_valid) begin
			bundle_q <= bundle;
		end
	end

	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> bundle_q.num != 2'd0)
		else $error("empty bundle held in result register");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < bundle_q.num)
		else $error("byte index ran past bundle size");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && out_ch.ready && last && !bundle_valid |=> !busy_q)
		else $error("result register not freed after last byte");

endmodule

>>> sv/base64_decoder_skip_invalid.sv
// Top level of the streaming base64 decoder that discards invalid characters.
// Depends on b64d_pkg, b64d_ifs, b64d_unpack and b64d_serial.
//
// in_ch carries one text character per word, with end_of_text on the last one.
// Characters outside A-Z, a-z, 0-9, '+' and '/' (padding included) are dropped.
// out_ch carries one decoded byte per word with the running byte count of the
// message (saturating) and run_last on the final byte caused by one input word.
//
// A character accepted at an edge is decoded in the cycle after that edge, and
// its bytes are registered in the result register before out_ch shows them.
// Characters that produce no bytes pass without touching the output side. The
// output side delivers one byte per cycle while out_ch is ready; the one-bundle
// result register decides the rate: a character that yields bytes waits only
// while the previous bundle is still draining. A message that ends with two
// sextets right after a full group can hold in_ch while that group's last byte
// drains.
//
// Reset clears the group, the byte count and all valid flags. When out_ch
// stalls, the held byte stays on the port, and in_ch keeps accepting
// characters until one needs the occupied result register.
module base64_decoder_skip_invalid (
	input logic clk,
	input logic arst_n,
	b64d_char_if.sink in_ch,
	b64d_byte_if.source out_ch
);
	import b64d_pkg::*;

	bundle_t bundle;
	logic bundle_valid;
	logic bundle_ready;

	b64d_unpack u_unpack (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.bundle(bundle),
		.bundle_valid(bundle_valid),
		.bundle_ready(bundle_ready)
	);

	b64d_serial u_serial (
		.clk(clk),
		.arst_n(arst_n),
		.bundle(bundle),
		.bundle_valid(bundle_valid),
		.bundle_ready(bundle_ready),
		.out_ch(out_ch)
	);

endmodule
